// ----- hdl/closest_point_on_triangle_assert.svh -----
// ----------------------------------------------------------------------------
// closest point on triangle assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define CPT_ASSERT_AFTER(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define CPT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define CPT_ASSERT_AFTER(label, clk, ante, cons, msg)
`endif
`endif

// ----- hdl/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg
// shared types, widths and codes of the closest point on triangle pipeline
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = FRAC_W;
    localparam int WIDE_W    = 74;

    typedef logic signed [16:0] diff_t;
    typedef logic signed [33:0] prod_t;
    typedef logic signed [35:0] dot_t;
    typedef logic signed [34:0] crs_t;
    typedef logic signed [69:0] tprd_t;
    typedef logic signed [71:0] vol_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [FRAC_W:0] frac_t;

    localparam frac_t ONE_Q16 = frac_t'(1) << FRAC_W;

    typedef logic [2:0][COORD_W-1:0] vec16_t;
    typedef logic [2:0][COORD_W:0]   vec17_t;

    localparam int NUM_DOTS = 6;
    localparam int DOT_SNOM = 0;
    localparam int DOT_SDEN = 1;
    localparam int DOT_TNOM = 2;
    localparam int DOT_TDEN = 3;
    localparam int DOT_UNOM = 4;
    localparam int DOT_UDEN = 5;

    localparam int NUM_VOLS = 3;
    localparam int VOL_A = 0;
    localparam int VOL_B = 1;
    localparam int VOL_C = 2;

    localparam int NUM_LANES = 3;
    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int LANE_E = 2;

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_C    = 3'd2,
        REG_AB   = 3'd3,
        REG_BC   = 3'd4,
        REG_CA   = 3'd5,
        REG_FACE = 3'd6
    } region_t;

    typedef struct packed {
        vec16_t a;
        vec16_t b;
        vec16_t c;
    } tri_t;

    typedef struct packed {
        region_t region;
        logic    degen;
        vec16_t  base;
        vec17_t  dir;
        tri_t    vtx;
    } side_t;

    function automatic diff_t sub16(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        return diff_t'($signed(x)) - diff_t'($signed(y));
    endfunction

endpackage

// ----- hdl/cpt_front.sv -----
// ----------------------------------------------------------------------------
// cpt_front
// differences, dot products, normal and triple products over five stages
// ----------------------------------------------------------------------------
module cpt_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cpt_pkg::vec16_t in_pnt,
    input  cpt_pkg::tri_t  in_tri,
    output logic           out_valid,
    output cpt_pkg::tri_t  out_tri,
    output cpt_pkg::dot_t  out_dot [cpt_pkg::NUM_DOTS],
    output cpt_pkg::vol_t  out_vol [cpt_pkg::NUM_VOLS]
);
    import cpt_pkg::*;

    localparam int STAGES    = 5;
    localparam int NUM_DIFFS = 9;
    localparam int DF_AB = 0;
    localparam int DF_AC = 1;
    localparam int DF_BC = 2;
    localparam int DF_PA = 3;
    localparam int DF_PB = 4;
    localparam int DF_PC = 5;
    localparam int DF_AP = 6;
    localparam int DF_BP = 7;
    localparam int DF_CP = 8;

    localparam int NUM_CROSS = 4;
    localparam int X_N = 0;
    localparam int X_A = 1;
    localparam int X_B = 2;
    localparam int X_C = 3;

    localparam int DOT_U [NUM_DOTS] = '{DF_PA, DF_PB, DF_PA, DF_PC, DF_PB, DF_PC};
    localparam int DOT_V [NUM_DOTS] = '{DF_AB, DF_AB, DF_AC, DF_AC, DF_BC, DF_BC};
    localparam logic [NUM_DOTS-1:0] DOT_NEG = 6'b101010;
    localparam int CRS_U [NUM_CROSS] = '{DF_AB, DF_BP, DF_CP, DF_AP};
    localparam int CRS_V [NUM_CROSS] = '{DF_AC, DF_CP, DF_AP, DF_BP};
    localparam int AXIS_J [3] = '{1, 2, 0};
    localparam int AXIS_K [3] = '{2, 0, 1};
    localparam int VOL_X [NUM_VOLS] = '{X_A, X_B, X_C};

    logic [STAGES-1:0] vld_reg;
    tri_t  tri_reg   [STAGES];
    diff_t diff_next [NUM_DIFFS][3];
    diff_t diff_reg  [NUM_DIFFS][3];
    prod_t dprod_reg [NUM_DOTS][3];
    prod_t xpos_reg  [NUM_CROSS][3];
    prod_t xneg_reg  [NUM_CROSS][3];
    dot_t  dot3_reg  [NUM_DOTS];
    dot_t  dot4_reg  [NUM_DOTS];
    dot_t  dot5_reg  [NUM_DOTS];
    crs_t  crs_reg   [NUM_CROSS][3];
    tprd_t tprod_reg [NUM_VOLS][3];
    vol_t  vol_reg   [NUM_VOLS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_next[DF_AB][i] = sub16(in_tri.b[i], in_tri.a[i]);
            diff_next[DF_AC][i] = sub16(in_tri.c[i], in_tri.a[i]);
            diff_next[DF_BC][i] = sub16(in_tri.c[i], in_tri.b[i]);
            diff_next[DF_PA][i] = sub16(in_pnt[i], in_tri.a[i]);
            diff_next[DF_PB][i] = sub16(in_pnt[i], in_tri.b[i]);
            diff_next[DF_PC][i] = sub16(in_pnt[i], in_tri.c[i]);
            diff_next[DF_AP][i] = sub16(in_tri.a[i], in_pnt[i]);
            diff_next[DF_BP][i] = sub16(in_tri.b[i], in_pnt[i]);
            diff_next[DF_CP][i] = sub16(in_tri.c[i], in_pnt[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_reg[0] <= in_tri;
            for (int s = 1; s < STAGES; s++) begin
                tri_reg[s] <= tri_reg[s-1];
            end
            diff_reg <= diff_next;
            for (int i = 0; i < 3; i++) begin
                for (int d = 0; d < NUM_DOTS; d++) begin
                    dprod_reg[d][i] <= diff_reg[DOT_U[d]][i] * diff_reg[DOT_V[d]][i];
                end
                for (int x = 0; x < NUM_CROSS; x++) begin
                    xpos_reg[x][i] <= diff_reg[CRS_U[x]][AXIS_J[i]]
                                    * diff_reg[CRS_V[x]][AXIS_K[i]];
                    xneg_reg[x][i] <= diff_reg[CRS_U[x]][AXIS_K[i]]
                                    * diff_reg[CRS_V[x]][AXIS_J[i]];
                    crs_reg[x][i]  <= crs_t'(xpos_reg[x][i]) - crs_t'(xneg_reg[x][i]);
                end
                for (int v = 0; v < NUM_VOLS; v++) begin
                    tprod_reg[v][i] <= crs_reg[X_N][i] * crs_reg[VOL_X[v]][i];
                end
            end
            for (int d = 0; d < NUM_DOTS; d++) begin
                if (DOT_NEG[d]) begin
                    dot3_reg[d] <= -(dot_t'(dprod_reg[d][0]) + dot_t'(dprod_reg[d][1])
                                   + dot_t'(dprod_reg[d][2]));
                end else begin
                    dot3_reg[d] <= dot_t'(dprod_reg[d][0]) + dot_t'(dprod_reg[d][1])
                                 + dot_t'(dprod_reg[d][2]);
                end
            end
            dot4_reg <= dot3_reg;
            dot5_reg <= dot4_reg;
            for (int v = 0; v < NUM_VOLS; v++) begin
                vol_reg[v] <= vol_t'(tprod_reg[v][0]) + vol_t'(tprod_reg[v][1])
                            + vol_t'(tprod_reg[v][2]);
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_tri   = tri_reg[STAGES-1];
    assign out_dot   = dot5_reg;
    assign out_vol   = vol_reg;

endmodule

// ----- hdl/cpt_class.sv -----
// ----------------------------------------------------------------------------
// cpt_class
// voronoi region tests and set-up of the three quotient lanes
// ----------------------------------------------------------------------------
module cpt_class (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cpt_pkg::tri_t  in_tri,
    input  cpt_pkg::dot_t  in_dot [cpt_pkg::NUM_DOTS],
    input  cpt_pkg::vol_t  in_vol [cpt_pkg::NUM_VOLS],
    output logic           out_valid,
    output cpt_pkg::wide_t out_num [cpt_pkg::NUM_LANES],
    output cpt_pkg::wide_t out_den [cpt_pkg::NUM_LANES],
    output cpt_pkg::side_t out_side
);
    import cpt_pkg::*;

    logic  vld_reg;
    wide_t num_next [NUM_LANES];
    wide_t den_next [NUM_LANES];
    wide_t num_reg  [NUM_LANES];
    wide_t den_reg  [NUM_LANES];
    side_t side_next;
    side_t side_reg;
    wide_t s_sum;
    dot_t  e_num;
    dot_t  e_den;

    always_comb begin
        s_sum = wide_t'(in_vol[VOL_A]) + wide_t'(in_vol[VOL_B]) + wide_t'(in_vol[VOL_C]);
        side_next.region = REG_A;
        side_next.degen  = 1'b0;
        side_next.base   = in_tri.a;
        side_next.dir    = '0;
        side_next.vtx    = in_tri;
        e_num = '0;
        e_den = '0;
        priority if (in_dot[DOT_SNOM] <= 0 && in_dot[DOT_TNOM] <= 0) begin
            side_next.region = REG_A;
        end else if (in_dot[DOT_SDEN] <= 0 && in_dot[DOT_UNOM] <= 0) begin
            side_next.region = REG_B;
            side_next.base   = in_tri.b;
        end else if (in_dot[DOT_TDEN] <= 0 && in_dot[DOT_UDEN] <= 0) begin
            side_next.region = REG_C;
            side_next.base   = in_tri.c;
        end else if (in_vol[VOL_C] <= 0 && in_dot[DOT_SNOM] >= 0
                     && in_dot[DOT_SDEN] >= 0) begin
            side_next.region = REG_AB;
            e_num = in_dot[DOT_SNOM];
            e_den = in_dot[DOT_SDEN];
            for (int i = 0; i < 3; i++) begin
                side_next.dir[i] = sub16(in_tri.b[i], in_tri.a[i]);
            end
        end else if (in_vol[VOL_A] <= 0 && in_dot[DOT_UNOM] >= 0
                     && in_dot[DOT_UDEN] >= 0) begin
            side_next.region = REG_BC;
            side_next.base   = in_tri.b;
            e_num = in_dot[DOT_UNOM];
            e_den = in_dot[DOT_UDEN];
            for (int i = 0; i < 3; i++) begin
                side_next.dir[i] = sub16(in_tri.c[i], in_tri.b[i]);
            end
        end else if (in_vol[VOL_B] <= 0 && in_dot[DOT_TNOM] >= 0
                     && in_dot[DOT_TDEN] >= 0) begin
            side_next.region = REG_CA;
            e_num = in_dot[DOT_TNOM];
            e_den = in_dot[DOT_TDEN];
            for (int i = 0; i < 3; i++) begin
                side_next.dir[i] = sub16(in_tri.c[i], in_tri.a[i]);
            end
        end else if (s_sum <= 0) begin
            side_next.region = REG_A;
            side_next.degen  = 1'b1;
        end else begin
            side_next.region = REG_FACE;
        end
        num_next[LANE_U] = wide_t'(in_vol[VOL_A]);
        num_next[LANE_V] = wide_t'(in_vol[VOL_B]);
        num_next[LANE_E] = wide_t'(e_num);
        den_next[LANE_U] = s_sum;
        den_next[LANE_V] = s_sum;
        den_next[LANE_E] = wide_t'(e_num) + wide_t'(e_den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ----- hdl/cpt_div.sv -----
// ----------------------------------------------------------------------------
// cpt_div
// pipelined restoring divider, one quotient bit per stage on three lanes
// ----------------------------------------------------------------------------
module cpt_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cpt_pkg::wide_t in_num [cpt_pkg::NUM_LANES],
    input  cpt_pkg::wide_t in_den [cpt_pkg::NUM_LANES],
    input  cpt_pkg::side_t in_side,
    output logic           out_valid,
    output cpt_pkg::frac_t out_q [cpt_pkg::NUM_LANES],
    output cpt_pkg::side_t out_side
);
    import cpt_pkg::*;

    logic [DIV_STEPS:0]  vld_reg;
    side_t               side_reg [DIV_STEPS+1];
    logic [WIDE_W-1:0]   rem_reg  [NUM_LANES][DIV_STEPS+1];
    logic [WIDE_W-1:0]   den_reg  [NUM_LANES][DIV_STEPS+1];
    logic [FRAC_W-1:0]   qb_reg   [NUM_LANES][DIV_STEPS+1];
    logic                zero_reg [NUM_LANES][DIV_STEPS+1];
    logic                full_reg [NUM_LANES][DIV_STEPS+1];
    logic [WIDE_W-1:0]   rem_next [NUM_LANES][DIV_STEPS];
    logic                ge_next  [NUM_LANES][DIV_STEPS];

    always_comb begin
        logic [WIDE_W:0] rem2;
        logic [WIDE_W:0] trial;
        for (int l = 0; l < NUM_LANES; l++) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                rem2  = {rem_reg[l][k], 1'b0};
                trial = rem2 - {1'b0, den_reg[l][k]};
                ge_next[l][k]  = !trial[WIDE_W];
                rem_next[l][k] = ge_next[l][k] ? trial[WIDE_W-1:0] : rem2[WIDE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < NUM_LANES; l++) begin
                rem_reg[l][0]  <= in_num[l];
                den_reg[l][0]  <= in_den[l];
                qb_reg[l][0]   <= '0;
                zero_reg[l][0] <= in_num[l] <= 0;
                full_reg[l][0] <= in_num[l] >= in_den[l];
                for (int k = 1; k <= DIV_STEPS; k++) begin
                    rem_reg[l][k]  <= rem_next[l][k-1];
                    den_reg[l][k]  <= den_reg[l][k-1];
                    qb_reg[l][k]   <= {qb_reg[l][k-1][FRAC_W-2:0], ge_next[l][k-1]};
                    zero_reg[l][k] <= zero_reg[l][k-1];
                    full_reg[l][k] <= full_reg[l][k-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            priority if (zero_reg[l][DIV_STEPS]) begin
                out_q[l] = '0;
            end else if (full_reg[l][DIV_STEPS]) begin
                out_q[l] = ONE_Q16;
            end else begin
                out_q[l] = {1'b0, qb_reg[l][DIV_STEPS]};
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

endmodule

// ----- hdl/cpt_blend.sv -----
// ----------------------------------------------------------------------------
// cpt_blend
// weight clamp, weighted vertex sums or base-plus-direction side points, and the output register
// ----------------------------------------------------------------------------
module cpt_blend (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  cpt_pkg::frac_t  in_q [cpt_pkg::NUM_LANES],
    input  cpt_pkg::side_t  in_side,
    output logic            out_valid,
    output cpt_pkg::vec16_t out_near,
    output cpt_pkg::region_t out_region,
    output logic            out_degen
);
    import cpt_pkg::*;

    typedef logic signed [34:0] bprd_t;
    typedef logic signed [36:0] bsum_t;

    logic [2:0]  vld_reg;
    frac_t       u_reg;
    frac_t       v_reg;
    frac_t       w_reg;
    frac_t       qe_reg;
    side_t       side0_reg;
    side_t       side1_reg;
    frac_t       cap;
    frac_t       v_sat;
    bprd_t       fprod_reg [3][3];
    bprd_t       eprod_reg [3];
    vec16_t      near_next;
    vec16_t      near_reg;
    region_t     region_reg;
    logic        degen_reg;
    bsum_t       face_sum;
    bsum_t       edge_sum;

    always_comb begin
        cap   = ONE_Q16 - in_q[LANE_U];
        v_sat = (in_q[LANE_V] > cap) ? cap : in_q[LANE_V];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            face_sum = bsum_t'(fprod_reg[0][i]) + bsum_t'(fprod_reg[1][i])
                     + bsum_t'(fprod_reg[2][i]);
            edge_sum = bsum_t'($signed({side1_reg.base[i], {FRAC_W{1'b0}}}))
                     + bsum_t'(eprod_reg[i]);
            if (side1_reg.region == REG_FACE) begin
                near_next[i] = face_sum[FRAC_W +: COORD_W];
            end else begin
                near_next[i] = edge_sum[FRAC_W +: COORD_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg     <= in_q[LANE_U];
            v_reg     <= v_sat;
            w_reg     <= cap - v_sat;
            qe_reg    <= in_q[LANE_E];
            side0_reg <= in_side;
            side1_reg <= side0_reg;
            for (int i = 0; i < 3; i++) begin
                fprod_reg[0][i] <= $signed({1'b0, u_reg}) * $signed(side0_reg.vtx.a[i]);
                fprod_reg[1][i] <= $signed({1'b0, v_reg}) * $signed(side0_reg.vtx.b[i]);
                fprod_reg[2][i] <= $signed({1'b0, w_reg}) * $signed(side0_reg.vtx.c[i]);
                eprod_reg[i]    <= $signed({1'b0, qe_reg}) * $signed(side0_reg.dir[i]);
            end
            near_reg   <= near_next;
            region_reg <= side1_reg.region;
            degen_reg  <= side1_reg.degen;
        end
    end

    assign out_valid  = vld_reg[2];
    assign out_near   = near_reg;
    assign out_region = region_reg;
    assign out_degen  = degen_reg;

endmodule

// ----- hdl/closest_point_on_triangle.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Takes one word per cycle while s_tready is high: a query point and a
// triangle in signed Q8.8, and returns the closest point on the triangle
// with its voronoi region. The pipeline depth is set by the five product
// stages, the region stage, the 17 stages of the one-bit-per-stage divider
// and three blend stages. The whole pipeline advances together and holds
// while a finished word waits on m_tready.
// ----------------------------------------------------------------------------
module closest_point_on_triangle (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // query_x, query_y, query_z, vert_a_x .. vert_a_z, vert_b_x .. vert_b_z,
    // vert_c_x .. vert_c_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // near_x, near_y, near_z
    output logic [47:0]  m_tdata,
    // region, degenerate
    output logic [3:0]   m_tuser
);
    import cpt_pkg::*;

    `include "closest_point_on_triangle_assert.svh"

    logic    en;
    vec16_t  in_pnt;
    tri_t    in_tri;
    logic    f_valid;
    tri_t    f_tri;
    dot_t    f_dot [NUM_DOTS];
    vol_t    f_vol [NUM_VOLS];
    logic    c_valid;
    wide_t   c_num [NUM_LANES];
    wide_t   c_den [NUM_LANES];
    side_t   c_side;
    logic    d_valid;
    frac_t   d_q [NUM_LANES];
    side_t   d_side;
    vec16_t  near;
    region_t region;
    logic    degen;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_pnt[i]   = s_tdata[COORD_W*i +: COORD_W];
            in_tri.a[i] = s_tdata[COORD_W*(3+i) +: COORD_W];
            in_tri.b[i] = s_tdata[COORD_W*(6+i) +: COORD_W];
            in_tri.c[i] = s_tdata[COORD_W*(9+i) +: COORD_W];
        end
    end

    cpt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_pnt    (in_pnt),
        .in_tri    (in_tri),
        .out_valid (f_valid),
        .out_tri   (f_tri),
        .out_dot   (f_dot),
        .out_vol   (f_vol)
    );

    cpt_class u_class (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_tri    (f_tri),
        .in_dot    (f_dot),
        .in_vol    (f_vol),
        .out_valid (c_valid),
        .out_num   (c_num),
        .out_den   (c_den),
        .out_side  (c_side)
    );

    cpt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c_valid),
        .in_num    (c_num),
        .in_den    (c_den),
        .in_side   (c_side),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    cpt_blend u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d_valid),
        .in_q       (d_q),
        .in_side    (d_side),
        .out_valid  (m_tvalid),
        .out_near   (near),
        .out_region (region),
        .out_degen  (degen)
    );

    assign m_tdata = {near[2], near[1], near[0]};
    assign m_tuser = {degen, region};

    `CPT_ASSERT_IMPLY(a_degen_gives_a, aclk, aresetn, m_tvalid && m_tuser[3],
        m_tuser[2:0] == REG_A, "degenerate word not in vertex a region")
    `CPT_ASSERT_IMPLY(a_face_not_degen, aclk, aresetn, m_tvalid && m_tuser[2:0] == REG_FACE,
        !m_tuser[3], "face word flagged degenerate")
    `CPT_ASSERT_AFTER(a_reset_empties, aclk, !aresetn, !m_tvalid,
        "output word valid after reset")

endmodule
